FILE: hw/rtl/gfsp_pkg.sv
// shared types and constants for the guillotine free-space packer
`timescale 1ns / 1ps
package gfsp_pkg;
  localparam int POOL_SLOTS = 1024;
  localparam int COORD_BITS = 16;
  localparam int SLOT_BITS  = $clog2(POOL_SLOTS);
  localparam int LINK_BITS  = SLOT_BITS + 1;
  localparam logic [LINK_BITS-1:0] NIL_SLOT = LINK_BITS'(POOL_SLOTS);

  localparam logic OP_START = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_STARTED = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } space_t;
endpackage

FILE: hw/rtl/gfsp_in_if.sv
// input channel interface of the packer
`timescale 1ns / 1ps
interface gfsp_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] width;
  logic [15:0] height;
  modport source (output valid, op, width, height, input ready);
  modport sink (input valid, op, width, height, output ready);
endinterface

FILE: hw/rtl/gfsp_out_if.sv
// result channel interface of the packer
`timescale 1ns / 1ps
interface gfsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  modport source (output valid, status, pos_x, pos_y, input ready);
  modport sink (input valid, status, pos_x, pos_y, output ready);
endinterface

FILE: hw/rtl/guillotine_free_space_packer_core.sv
// top level of the guillotine free-space packer: list walker and splitter
`timescale 1ns / 1ps
// The block keeps a linked list of free rectangles in one bin, newest first,
// held in two memories of POOL_SLOTS entries (rectangles and next links) with
// registered reads. One item is handled at a time; ready is low while it works
// and the result sits in an output register until transferred. After reset a
// clearing pass chains every link slot to the next, during which no item is
// accepted. A start item reruns that same pass and then pushes the bin. A place
// item reads both memories once per list entry visited, stepping through the
// request, wait and test states for each entry, then unlinks the fitting entry
// and frees its slot, pushes up to two remainders, each with a fetch and a
// write state, and posts the result, so its time is set by how far down the
// list the first fitting space lies. One shared set of compare and subtract
// logic does the fit test and the remainder sizes.
module guillotine_free_space_packer_core
  import gfsp_pkg::*;
(
  input logic clk,
  input logic rst,
  gfsp_in_if.sink    in_ch,
  gfsp_out_if.source out_ch
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_RDREQ  = 12'b000000000100,
    S_RDWAIT = 12'b000000001000,
    S_TEST   = 12'b000000010000,
    S_UNLINK = 12'b000000100000,
    S_FREE   = 12'b000001000000,
    S_PUSHA  = 12'b000010000000,
    S_PUSHA2 = 12'b000100000000,
    S_PUSHB  = 12'b001000000000,
    S_PUSHB2 = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  state_t state;
  space_t rect_mem [POOL_SLOTS];
  logic [LINK_BITS-1:0] link_mem [POOL_SLOTS];
  space_t rect_rd;
  logic [LINK_BITS-1:0] link_rd;

  logic [LINK_BITS-1:0] used_head, spare_head, used_count;
  logic [LINK_BITS-1:0] prev, cur, steps, cur_next;
  logic [LINK_BITS-1:0] clr_idx;
  logic                 start_pend;
  logic                 op;
  logic [COORD_BITS-1:0] rw, rh;
  space_t push_a, push_b;
  logic [1:0] npush;
  logic out_valid;
  logic [1:0] status;
  logic [15:0] pos_x, pos_y;

  // memory ports
  logic                 rd_en;
  logic [SLOT_BITS-1:0] rd_addr;
  logic                 rect_we, link_we;
  logic [SLOT_BITS-1:0] rect_wa, link_wa;
  space_t               rect_wd;
  logic [LINK_BITS-1:0] link_wd;

  always_ff @(posedge clk) begin
    if (rect_we) rect_mem[rect_wa] <= rect_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
    if (rd_en) begin
      rect_rd <= rect_mem[rd_addr];
      link_rd <= link_mem[rd_addr];
    end
  end

  // shared compare/subtract unit
  logic fit, wide_eq, high_eq, dw_gt;
  logic [COORD_BITS-1:0] dw, dh;
  assign fit     = (rw <= rect_rd.w) && (rh <= rect_rd.h);
  assign wide_eq = rw == rect_rd.w;
  assign high_eq = rh == rect_rd.h;
  assign dw      = rect_rd.w - rw;
  assign dh      = rect_rd.h - rh;
  assign dw_gt   = dw > dh;

  assign in_ch.ready   = (state == S_IDLE) && !out_valid;
  assign out_ch.valid  = out_valid;
  assign out_ch.status = status;
  assign out_ch.pos_x  = pos_x;
  assign out_ch.pos_y  = pos_y;

  logic [SLOT_BITS-1:0] spare_slot;
  assign spare_slot = spare_head[SLOT_BITS-1:0];

  always_comb begin
    rd_en = 1'b0; rd_addr = cur[SLOT_BITS-1:0];
    rect_we = 1'b0; link_we = 1'b0;
    rect_wa = spare_slot; link_wa = spare_slot;
    rect_wd = push_a; link_wd = used_head;
    unique case (state)
      S_CLEAR: begin
        link_we = 1'b1;
        link_wa = clr_idx[SLOT_BITS-1:0];
        link_wd = clr_idx + 1'b1;
      end
      S_RDREQ: rd_en = 1'b1;
      S_UNLINK: begin
        link_we = prev != NIL_SLOT;
        link_wa = prev[SLOT_BITS-1:0];
        link_wd = cur_next;
      end
      S_FREE: begin
        link_we = 1'b1;
        link_wa = cur[SLOT_BITS-1:0];
        link_wd = spare_head;
      end
      S_PUSHA: rd_en = 1'b1;
      S_PUSHB: rd_en = 1'b1;
      S_PUSHA2, S_PUSHB2: begin
        rect_we = 1'b1;
        link_we = 1'b1;
        rect_wd = (state == S_PUSHA2) ? push_a : push_b;
      end
      default: ;
    endcase
    if (state == S_PUSHA || state == S_PUSHB) rd_addr = spare_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_idx <= '0; start_pend <= 1'b0;
      out_valid <= 1'b0; used_head <= NIL_SLOT; spare_head <= '0;
      used_count <= '0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == NIL_SLOT - 1'b1) begin
            used_head <= NIL_SLOT; spare_head <= '0; used_count <= '0;
            if (start_pend) begin
              // push the whole bin
              start_pend <= 1'b0;
              push_a <= '{x: '0, y: '0, w: rw, h: rh};
              npush <= 2'd1;
              state <= S_PUSHA;
            end else state <= S_IDLE;
          end
        end
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          op <= in_ch.op; rw <= in_ch.width; rh <= in_ch.height;
          status <= ST_NOFIT; pos_x <= '0; pos_y <= '0;
          prev <= NIL_SLOT; cur <= used_head; steps <= '0;
          if (in_ch.op == OP_START) begin
            start_pend <= 1'b1; clr_idx <= '0; state <= S_CLEAR;
          end else state <= S_RDREQ;
        end
        S_RDREQ: begin
          if (cur == NIL_SLOT || steps >= used_count) state <= S_DONE;
          else state <= S_RDWAIT;
        end
        S_RDWAIT: state <= S_TEST;
        S_TEST: begin
          cur_next <= link_rd;
          if (fit) begin
            if (!wide_eq && !high_eq && used_count >= NIL_SLOT) begin
              status <= ST_FULL; state <= S_DONE;
            end else begin
              status <= ST_PLACED;
              pos_x <= 16'(rect_rd.x); pos_y <= 16'(rect_rd.y);
              npush <= (wide_eq && high_eq) ? 2'd0 :
                       (wide_eq || high_eq) ? 2'd1 : 2'd2;
              if (wide_eq) push_a <= '{rect_rd.x, rect_rd.y + rh, rect_rd.w, dh};
              else if (high_eq) push_a <= '{rect_rd.x + rw, rect_rd.y, dw, rect_rd.h};
              else if (dw_gt) begin
                push_a <= '{rect_rd.x + rw, rect_rd.y, dw, rect_rd.h};
                push_b <= '{rect_rd.x, rect_rd.y + rh, rw, dh};
              end else begin
                push_a <= '{rect_rd.x, rect_rd.y + rh, rect_rd.w, dh};
                push_b <= '{rect_rd.x + rw, rect_rd.y, dw, rh};
              end
              state <= S_UNLINK;
            end
          end else begin
            prev <= cur; cur <= link_rd; steps <= steps + 1'b1;
            state <= S_RDREQ;
          end
        end
        S_UNLINK: begin
          if (prev == NIL_SLOT) used_head <= cur_next;
          state <= S_FREE;
        end
        S_FREE: begin
          spare_head <= cur; used_count <= used_count - 1'b1;
          state <= (npush == 2'd0) ? S_DONE : S_PUSHA;
        end
        S_PUSHA: state <= S_PUSHA2;  // fetch link of spare slot
        S_PUSHA2: begin
          spare_head <= link_rd; used_head <= spare_head;
          used_count <= used_count + 1'b1;
          state <= (npush == 2'd2) ? S_PUSHB : S_DONE;
        end
        S_PUSHB: state <= S_PUSHB2;
        S_PUSHB2: begin
          spare_head <= link_rd; used_head <= spare_head;
          used_count <= used_count + 1'b1;
          state <= S_DONE;
        end
        S_DONE: if (!out_valid) begin
          if (op == OP_START) status <= ST_STARTED;
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    used_count <= NIL_SLOT) else $error("used count over pool size");
  a_full_no_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (pos_x == '0 && pos_y == '0))
    else $error("pool full result carries a position");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> (state == S_IDLE)) else $error("ready outside idle");

endmodule

FILE: tb/tb.sv
// self-checking testbench for the guillotine free-space packer core
`timescale 1ns / 1ps
module tb;
  import gfsp_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int RANDOM_ITEMS = 250;
  localparam int DRAIN_CYCLES = 4 * POOL_SLOTS;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } placement_t;

  // one directed stimulus row; typed marks a row whose result is checked against its own expected value
  typedef struct {
    logic        op;
    logic [15:0] w;
    logic [15:0] h;
    bit          typed;
    placement_t  res;
  } stim_row_t;

  logic clk;
  logic rst;
  int   cycles = 0;
  int   errors = 0;

  gfsp_in_if  in_ch ();
  gfsp_out_if out_ch ();

  guillotine_free_space_packer_core DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // shadow free-space list, kept the same way the block keeps it
  logic [15:0] free_x [POOL_SLOTS];
  logic [15:0] free_y [POOL_SLOTS];
  logic [15:0] free_w [POOL_SLOTS];
  logic [15:0] free_h [POOL_SLOTS];
  int          free_next [POOL_SLOTS];
  int          list_head;
  int          spare_slot;
  int          list_len;

  placement_t  pending_results [$];
  placement_t  typed_results [$];
  bit          typed_flags [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_bin();
    for (int i = 0; i < POOL_SLOTS; i++) free_next[i] = i + 1;
    list_head  = POOL_SLOTS;
    spare_slot = 0;
    list_len   = 0;
  endfunction

  function automatic void push_free(int x, int y, int w, int h);
    int s;
    s = spare_slot;
    if (s >= POOL_SLOTS) return;
    spare_slot   = free_next[s];
    free_x[s]    = x[15:0];
    free_y[s]    = y[15:0];
    free_w[s]    = w[15:0];
    free_h[s]    = h[15:0];
    free_next[s] = list_head;
    list_head    = s;
    list_len++;
  endfunction

  // first-fit walk, split and result for one accepted item
  function automatic placement_t pack_item(logic op, logic [15:0] rw16, logic [15:0] rh16);
    placement_t r;
    int prev, cur, steps, rw, rh, sx, sy, sw, sh, dw, dh;
    bit weq, heq;
    r = '{status: ST_NOFIT, pos_x: 16'd0, pos_y: 16'd0};
    rw = rw16;
    rh = rh16;
    if (op == OP_START) begin
      clear_bin();
      push_free(0, 0, rw, rh);
      r.status = ST_STARTED;
      return r;
    end
    prev  = POOL_SLOTS;
    cur   = list_head;
    steps = 0;
    while (cur < POOL_SLOTS && steps < list_len) begin
      sx = free_x[cur];
      sy = free_y[cur];
      sw = free_w[cur];
      sh = free_h[cur];
      if (rw <= sw && rh <= sh) begin
        weq = (rw == sw);
        heq = (rh == sh);
        // two remainders but no spare slot: refuse, state kept
        if (!weq && !heq && list_len >= POOL_SLOTS) begin
          r.status = ST_FULL;
          return r;
        end
        if (prev >= POOL_SLOTS) list_head = free_next[cur];
        else free_next[prev] = free_next[cur];
        free_next[cur] = spare_slot;
        spare_slot = cur;
        list_len--;
        if (weq && !heq) begin
          push_free(sx, sy + rh, sw, sh - rh);
        end else if (!weq && heq) begin
          push_free(sx + rw, sy, sw - rw, sh);
        end else if (!weq && !heq) begin
          dw = sw - rw;
          dh = sh - rh;
          if (dw > dh) begin
            push_free(sx + rw, sy, dw, sh);
            push_free(sx, sy + rh, rw, dh);
          end else begin
            push_free(sx, sy + rh, sw, dh);
            push_free(sx + rw, sy, dw, rh);
          end
        end
        r.status = ST_PLACED;
        r.pos_x  = sx[15:0];
        r.pos_y  = sy[15:0];
        return r;
      end
      prev = cur;
      cur  = free_next[cur];
      steps++;
    end
    return r;
  endfunction

  // one input transfer; valid is only lowered when a gap is drawn
  task automatic send_item(logic op, logic [15:0] w, logic [15:0] h, bit typed,
                           placement_t res);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.width  <= w;
    in_ch.height <= h;
    do @(posedge clk); while (!in_ch.ready);
    // transfer happened at this edge: predict in acceptance order
    pending_results.push_back(pack_item(op, w, h));
    typed_flags.push_back(typed);
    typed_results.push_back(res);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side stalls: per result draw a low-ready stretch, then hold high
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // result checker against the oldest pending prediction
  always @(posedge clk) begin
    placement_t want, got;
    bit typed;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{status: out_ch.status, pos_x: out_ch.pos_x, pos_y: out_ch.pos_y};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d x=%0d y=%0d", $time,
                 got.status, got.pos_x, got.pos_y);
        errors++;
      end else begin
        want  = pending_results.pop_front();
        typed = typed_flags.pop_front();
        // typed rows are checked against their own expected result instead of the prediction
        if (typed) want = typed_results.pop_front();
        else void'(typed_results.pop_front());
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.pos_x !== want.pos_x) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, got.pos_x);
          errors++;
        end
        if (got.pos_y !== want.pos_y) begin
          $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, got.pos_y);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] pick_size(int bound);
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      3, 4: return 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, bound));
    endcase
  endfunction

  stim_row_t directed [] = '{
    // place before any start: empty list
    '{OP_PLACE, 16'd1, 16'd1, 1, '{ST_NOFIT, 16'd0, 16'd0}},
    '{OP_START, 16'hFFFF, 16'hFFFF, 1, '{ST_STARTED, 16'd0, 16'd0}},
    // exact fit of the largest bin
    '{OP_PLACE, 16'hFFFF, 16'hFFFF, 1, '{ST_PLACED, 16'd0, 16'd0}},
    '{OP_PLACE, 16'd0, 16'd0, 1, '{ST_NOFIT, 16'd0, 16'd0}},
    '{OP_START, 16'd100, 16'd50, 1, '{ST_STARTED, 16'd0, 16'd0}},
    // height matches
    '{OP_PLACE, 16'd30, 16'd50, 1, '{ST_PLACED, 16'd0, 16'd0}},
    // width matches
    '{OP_PLACE, 16'd70, 16'd20, 1, '{ST_PLACED, 16'd30, 16'd0}},
    // both smaller, wider slack
    '{OP_PLACE, 16'd10, 16'd10, 0, '{ST_NOFIT, 16'd0, 16'd0}},
    '{OP_PLACE, 16'd0, 16'd0, 0, '{ST_NOFIT, 16'd0, 16'd0}},
    '{OP_PLACE, 16'd200, 16'd1, 1, '{ST_NOFIT, 16'd0, 16'd0}},
    '{OP_PLACE, 16'd5, 16'd3, 0, '{ST_NOFIT, 16'd0, 16'd0}},
    '{OP_START, 16'd0, 16'd0, 1, '{ST_STARTED, 16'd0, 16'd0}},
    '{OP_PLACE, 16'd0, 16'd0, 1, '{ST_PLACED, 16'd0, 16'd0}},
    '{OP_START, 16'd10, 16'd100, 1, '{ST_STARTED, 16'd0, 16'd0}},
    // both smaller, taller slack
    '{OP_PLACE, 16'd3, 16'd4, 1, '{ST_PLACED, 16'd0, 16'd0}},
    '{OP_PLACE, 16'd7, 16'd4, 0, '{ST_NOFIT, 16'd0, 16'd0}},
    '{OP_PLACE, 16'd10, 16'd96, 0, '{ST_NOFIT, 16'd0, 16'd0}},
    '{OP_PLACE, 16'hFFFF, 16'd0, 1, '{ST_NOFIT, 16'd0, 16'd0}},
    '{OP_PLACE, 16'd0, 16'hFFFF, 1, '{ST_NOFIT, 16'd0, 16'd0}},
    '{OP_START, 16'hFFFF, 16'd0, 1, '{ST_STARTED, 16'd0, 16'd0}},
    '{OP_PLACE, 16'd1, 16'd0, 0, '{ST_NOFIT, 16'd0, 16'd0}},
    '{OP_PLACE, 16'hAAAA, 16'd0, 0, '{ST_NOFIT, 16'd0, 16'd0}},
    '{OP_START, 16'h5555, 16'hAAAA, 1, '{ST_STARTED, 16'd0, 16'd0}},
    '{OP_PLACE, 16'h5555, 16'h5555, 0, '{ST_NOFIT, 16'd0, 16'd0}}
  };

  initial begin
    logic [15:0] bin_w, bin_h, w, h;
    logic        op;
    int          since_start;
    rst          = 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.op     <= OP_START;
    in_ch.width  <= 16'd0;
    in_ch.height <= 16'd0;
    clear_bin();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_item(directed[i].op, directed[i].w, directed[i].h, directed[i].typed,
                directed[i].res);

    // sender holds off until every result is back
    in_ch.valid <= 1'b0;
    wait_drained();

    // pool fill: each wide zero-height place keeps the bin and adds a
    // sliver that later places skip, until no spare slot is left
    send_item(OP_START, 16'hFFFF, 16'hFFFF, 0, '0);
    for (int i = 0; i < POOL_SLOTS + 1; i++)
      send_item(OP_PLACE, 16'd40000, 16'd0, 0, '0);
    // an exact fit of a sliver still goes through on a full pool
    send_item(OP_PLACE, 16'd25535, 16'd0, 0, '0);
    send_item(OP_PLACE, 16'd40000, 16'd0, 0, '0);

    // random bins with mostly plausible rectangles
    bin_w = 16'd0;
    bin_h = 16'd0;
    since_start = 100;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (since_start > $urandom_range(10, 40) || $urandom_range(0, 49) == 0) begin
        op = OP_START;
        if ($urandom_range(0, 3) == 0) begin
          bin_w = pick_size(65535);
          bin_h = pick_size(65535);
        end else begin
          bin_w = 16'($urandom_range(1, 1000));
          bin_h = 16'($urandom_range(1, 1000));
        end
        w = bin_w;
        h = bin_h;
        since_start = 0;
      end else begin
        op = OP_PLACE;
        w  = pick_size(bin_w / 3);
        h  = pick_size(bin_h / 3);
        since_start++;
      end
      send_item(op, w, h, 0, '0);
    end
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
